// ===== sv/bea_pkg.sv =====
// Shared types, constants and helpers for the button edge and auto-repeat block.
// No dependencies; imported by every module under sv/.
package bea_pkg;

    localparam int NUM_BUTTONS = 17;
    localparam int NUM_AXES    = 4;
    localparam int AXIS_W      = 8;
    localparam int THR_W       = 7;
    localparam int STICK_BASE  = NUM_BUTTONS;
    localparam int NUM_SIGNALS = NUM_BUTTONS + 2 * NUM_AXES;
    localparam int OUT_W       = NUM_SIGNALS + 2;
    localparam int CNT_W       = 4;

    localparam int SIG_CIRCLE = 5;
    localparam int SIG_CROSS  = 6;

    localparam logic [CNT_W-1:0] REPEAT_DELAY = CNT_W'(10);
    localparam logic [CNT_W-1:0] SLOW_RELOAD  = CNT_W'(6);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTER_SEL = 2'd2;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 136;

    typedef logic [NUM_SIGNALS-1:0] sig_vec_t;
    typedef logic [OUT_W-1:0]       out_vec_t;

    // Per-lane repeat control and pulses.
    typedef struct packed {
        logic en;
        logic held;
    } rep_ctl_t;

    typedef struct packed {
        logic slow;
        logic fast;
    } rep_fire_t;

    // Append enter and cancel aliases above the signal bits.
    function automatic out_vec_t with_alias(input sig_vec_t m, input logic enter_is_circle);
        logic en;
        logic ca;
        en = enter_is_circle ? m[SIG_CIRCLE] : m[SIG_CROSS];
        ca = enter_is_circle ? m[SIG_CROSS] : m[SIG_CIRCLE];
        return {ca, en, m};
    endfunction

endpackage

// ===== sv/bea_axis_lane.sv =====
// One stick axis lane: turns an 8-bit axis into low and high direction bits.
// Depends on bea_pkg.
module bea_axis_lane
    import bea_pkg::*;
(
    input  logic [AXIS_W-1:0] axis,
    input  logic [AXIS_W-1:0] center,
    input  logic [THR_W-1:0]  threshold,
    output logic [1:0]        dir
);

    logic [AXIS_W:0] axis_plus_thr;
    logic [AXIS_W:0] center_plus_thr;

    // Compare at one extra bit so bounds outside the axis range never trip.
    assign axis_plus_thr   = {1'b0, axis} + {2'b00, threshold};
    assign center_plus_thr = {1'b0, center} + {2'b00, threshold};

    always_comb begin
        dir = 2'b00;
        if (axis_plus_thr < {1'b0, center}) begin
            dir[0] = 1'b1;
        end else if ({1'b0, axis} > center_plus_thr) begin
            dir[1] = 1'b1;
        end
    end

endmodule

// ===== sv/bea_repeat_lane.sv =====
// One signal's auto-repeat lane: slow and fast repeat counters.
// Depends on bea_pkg.
module bea_repeat_lane
    import bea_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  rep_ctl_t  ctl,
    output rep_fire_t fire
);

    logic [CNT_W-1:0] slow_cnt_reg, slow_cnt_next;
    logic [CNT_W-1:0] fast_cnt_reg, fast_cnt_next;

    // Pulses depend only on held and the counter reaching REPEAT_DELAY, not on en.
    assign fire.slow = ctl.held && (slow_cnt_reg >= REPEAT_DELAY);
    assign fire.fast = ctl.held && (fast_cnt_reg >= REPEAT_DELAY);

    always_comb begin
        slow_cnt_next = slow_cnt_reg;
        fast_cnt_next = fast_cnt_reg;
        if (ctl.en) begin
            if (ctl.held) begin
                slow_cnt_next = (fire.slow ? SLOW_RELOAD : slow_cnt_reg) + CNT_W'(1);
                fast_cnt_next = (fire.fast ? REPEAT_DELAY : fast_cnt_reg) + CNT_W'(1);
            end else begin
                slow_cnt_next = '0;
                fast_cnt_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slow_cnt_reg <= '0;
            fast_cnt_reg <= '0;
        end else begin
            slow_cnt_reg <= slow_cnt_next;
            fast_cnt_reg <= fast_cnt_next;
        end
    end

endmodule

// ===== sv/button_edge_and_autorepeat.sv =====
// Top level of the button edge and auto-repeat block.
// Depends on bea_pkg, bea_axis_lane and bea_repeat_lane.
//
// Usage:
//   s_* stream carries one controller port sample per transaction. s_tuser is
//   the function (0 sample, 1 clear pad vectors), s_tlast marks the last port
//   of a poll. A sample transaction with s_tlast high ends the poll and yields
//   one result transaction on m_*; other transactions yield none.
//   cfg_* writes the stick center, the stick threshold and the enter/cancel
//   selection; cfg_ready is always high. Write only while the block is idle.
// Latency and throughput:
//   One input transaction per cycle while m_* is not stalled. The axis compares, the poll
//   OR and all 25 repeat lanes settle in the accept cycle, so the result is
//   on m_* in the cycle after the closing sample. The single output register
//   sets the rate: a new sample is taken whenever that register is empty or
//   is being drained in the same cycle.
// Stall:
//   While m_tready is low and a result waits, s_tready drops and the result
//   holds; nothing is lost or duplicated.
// Reset:
//   aresetn low (synchronous) clears the poll accumulator, previous signals,
//   all repeat counters and the output valid, and restores center 128,
//   threshold 64 and enter on cross.
module button_edge_and_autorepeat
    import bea_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // Input sample stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [16:0] buttons, [24:17] left_x, [32:25] left_y, [40:33] right_x,
    // [48:41] right_y, [49] port_ok, [55:50] zero
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // [0] func
    input  logic                   s_tuser,
    // last_port
    input  logic                   s_tlast,
    // Result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [26:0] held_mask, [53:27] pressed_mask, [80:54] released_mask,
    // [107:81] repeat_slow_mask, [134:108] repeat_fast_mask, [135] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // Configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // ---------------- configuration registers ----------------
    logic [AXIS_W-1:0] center_reg;
    logic [THR_W-1:0]  threshold_reg;
    logic              enter_circle_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg       <= AXIS_W'(128);
            threshold_reg    <= THR_W'(64);
            enter_circle_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_CENTER:    center_reg       <= cfg_data[AXIS_W-1:0];
                CFG_THRESHOLD: threshold_reg    <= cfg_data[THR_W-1:0];
                CFG_ENTER_SEL: enter_circle_reg <= cfg_data[0];
                default: begin
                    // Drop writes to unmapped indexes.
                end
            endcase
        end
    end

    // ---------------- input unpacking ----------------
    logic [NUM_BUTTONS-1:0]        buttons;
    logic [NUM_AXES-1:0][AXIS_W-1:0] axes;
    logic                          port_ok;
    logic                          in_accept;
    logic                          end_of_poll;

    assign buttons  = s_tdata[NUM_BUTTONS-1:0];
    assign axes     = s_tdata[NUM_BUTTONS + NUM_AXES*AXIS_W - 1 : NUM_BUTTONS];
    assign port_ok  = s_tdata[NUM_BUTTONS + NUM_AXES*AXIS_W];

    assign in_accept   = s_tvalid && s_tready;
    assign end_of_poll = in_accept && !s_tuser && s_tlast;

    // ---------------- axis lanes ----------------
    logic [NUM_AXES-1:0][1:0] dirs;

    genvar ai;
    generate
        for (ai = 0; ai < NUM_AXES; ai++) begin : g_axis
            bea_axis_lane u_axis (
                .axis      (axes[ai]),
                .center    (center_reg),
                .threshold (threshold_reg),
                .dir       (dirs[ai])
            );
        end
    endgenerate

    // ---------------- poll accumulation ----------------
    sig_vec_t acc_reg, acc_next;
    sig_vec_t prev_reg, prev_next;
    sig_vec_t sample;
    sig_vec_t cur;

    // Directions sit above the buttons, two bits per axis.
    assign sample = {dirs, buttons};
    assign cur    = acc_reg | (port_ok ? sample : '0);

    always_comb begin
        acc_next  = acc_reg;
        prev_next = prev_reg;
        if (in_accept) begin
            if (s_tuser) begin
                acc_next  = '0;
                prev_next = '0;
            end else if (s_tlast) begin
                acc_next  = '0;
                prev_next = cur;
            end else begin
                acc_next  = cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            prev_reg <= '0;
        end else begin
            acc_reg  <= acc_next;
            prev_reg <= prev_next;
        end
    end

    // ---------------- repeat lanes ----------------
    rep_ctl_t  [NUM_SIGNALS-1:0] lane_ctl;
    rep_fire_t [NUM_SIGNALS-1:0] lane_fire;
    sig_vec_t  slow_fire;
    sig_vec_t  fast_fire;

    genvar li;
    generate
        for (li = 0; li < NUM_SIGNALS; li++) begin : g_lane
            assign lane_ctl[li].en   = end_of_poll;
            assign lane_ctl[li].held = cur[li];
            assign slow_fire[li]     = lane_fire[li].slow;
            assign fast_fire[li]     = lane_fire[li].fast;

            bea_repeat_lane u_lane (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl     (lane_ctl[li]),
                .fire    (lane_fire[li])
            );
        end
    endgenerate

    // ---------------- merge ----------------
    sig_vec_t pressed;
    sig_vec_t released;
    out_vec_t held_o, pressed_o, released_o, slow_o, fast_o;

    assign pressed    = cur & ~prev_reg;
    assign released   = prev_reg & ~cur;
    assign held_o     = with_alias(cur, enter_circle_reg);
    assign pressed_o  = with_alias(pressed, enter_circle_reg);
    assign released_o = with_alias(released, enter_circle_reg);
    assign slow_o     = with_alias(pressed | slow_fire, enter_circle_reg);
    assign fast_o     = with_alias(pressed | fast_fire, enter_circle_reg);

    // ---------------- output register ----------------
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg;

    // Accept when the output slot is free or drains this cycle.
    assign s_tready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (end_of_poll) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (end_of_poll) begin
            m_data_reg <= {1'b0, fast_o, slow_o, released_o, pressed_o, held_o};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    // Pressed and released never overlap in one result.
    a_press_release_disjoint: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[2*OUT_W-1:OUT_W] & m_tdata[3*OUT_W-1:2*OUT_W]) == '0))
        else $error("pressed and released overlap");

    // A press is always held and always carried by both repeat masks.
    a_press_implies: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (((m_tdata[2*OUT_W-1:OUT_W] & ~m_tdata[OUT_W-1:0]) == '0) &&
                      ((m_tdata[2*OUT_W-1:OUT_W] & ~m_tdata[4*OUT_W-1:3*OUT_W]) == '0) &&
                      ((m_tdata[2*OUT_W-1:OUT_W] & ~m_tdata[5*OUT_W-1:4*OUT_W]) == '0)))
        else $error("pressed bit missing from held or repeat mask");

    // A clear transaction produces no result.
    a_clear_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser) |=> !m_tvalid)
        else $error("result after clear transaction");

    // A closing sample always produces a result in the next cycle.
    a_poll_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !s_tuser && s_tlast) |=> m_tvalid)
        else $error("closing sample without result");
`endif

endmodule
